// ===== hw/rtl/lelmq_pkg.sv =====
// ----------------------------------------------------------------------------
// lelmq_pkg
// Shared types and constants for the lower-envelope line store with
// minimum query.
// ----------------------------------------------------------------------------
`default_nettype none

package lelmq_pkg;

  // Field widths
  localparam int LINE_W    = 32;
  localparam int DIFF_W    = LINE_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int VAL_W     = 64;
  localparam int STAT_W    = 2;
  localparam int HELD_W    = 11;
  localparam int S_TDATA_W = 3 * LINE_W;
  localparam int M_TDATA_W = 80;

  // Default envelope depth
  localparam int MAX_LINES_DEF = 1024;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_SLOPE = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_TOP,
    S_RD_PREV,
    S_DIFF,
    S_MUL_A,
    S_MUL_B,
    S_CMP,
    S_PUSH,
    S_QLOOP,
    S_QMUL,
    S_QADD,
    S_DONE
  } state_e;

  // Which line a query evaluation belongs to
  typedef enum logic [1:0] {
    QS_MID,
    QS_NEXT,
    QS_FINAL
  } qsel_e;

  // Request to the shared multiplier
  typedef struct packed {
    logic                     en;
    logic signed [DIFF_W-1:0] op_a;
    logic signed [DIFF_W-1:0] op_b;
  } mul_req_t;

endpackage : lelmq_pkg

`default_nettype wire

// ===== hw/rtl/lelmq_ram.sv =====
// ----------------------------------------------------------------------------
// lelmq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lelmq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule : lelmq_ram

`default_nettype wire

// ===== hw/rtl/lelmq_mul.sv =====
// ----------------------------------------------------------------------------
// lelmq_mul
// Shared signed 33 x 33 multiplier with a registered 66-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module lelmq_mul (
  input  wire logic                                  clk_i,
  input  wire lelmq_pkg::mul_req_t                   req_i,
  output logic signed [lelmq_pkg::PROD_W-1:0]        prod_o
);

  // Multiply and register the product
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_o <= req_i.op_a * req_i.op_b;
    end
  end

endmodule : lelmq_mul

`default_nettype wire

// ===== hw/rtl/lower_envelope_line_min_query.sv =====
// An add tests top lines for removal one by one, testing none on an empty store
// or with a slope out of order; a query takes at most ceil(log2(lines held))
// search steps, and none on an empty store.
// Throughput: one item at a time; input is ready only between items, while a
// finished result may still wait in the output register.
// Reset clears the line count; line storage is left as it is.
// ----------------------------------------------------------------------------
// lower_envelope_line_min_query
// Lower envelope of lines with non-increasing slopes, minimum query by
// binary search, sequenced over one RAM and one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module lower_envelope_line_min_query #(
  parameter int MAX_LINES = lelmq_pkg::MAX_LINES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // slope [31:0], intercept [63:32], query_x [95:64]
  input  wire logic [lelmq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // func [0]
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // min_value [63:0], status [65:64], lines_held [76:66], zero [79:77]
  output logic      [lelmq_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  localparam int AW = $clog2(MAX_LINES);
  localparam int CW = $clog2(MAX_LINES + 1);
  localparam int LW = lelmq_pkg::LINE_W;
  localparam int DW = lelmq_pkg::DIFF_W;
  localparam int PW = lelmq_pkg::PROD_W;

  lelmq_pkg::state_e  state_q, state_d;
  lelmq_pkg::qsel_e   qsel_q;
  lelmq_pkg::status_e res_stat_q;
  lelmq_pkg::mul_req_t mul_req;

  logic [CW-1:0]        cnt_q, n_q;
  logic [AW-1:0]        lo_q, hi_q, mid;
  logic [AW:0]          mid_sum;
  logic signed [LW-1:0] a_q, b_q, x_q, top_a_q, top_b_q, icpt_q;
  logic signed [LW-1:0] rd_slope, rd_icpt, in_slope;
  logic signed [DW-1:0] p1_q, q1_q, p2_q, q2_q;
  logic signed [PW-1:0] prod, m1_q, v1_q, val;
  logic [lelmq_pkg::VAL_W-1:0] res_val_q;
  logic [2*LW-1:0]      rd_data;
  logic                 ram_rd_en, ram_wr_en, accept, out_free, keep_top, full;
  logic [AW-1:0]        ram_rd_addr;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign in_slope = $signed(s_axis_tdata[LW-1:0]);
  assign rd_slope = $signed(rd_data[2*LW-1:LW]);
  assign rd_icpt  = $signed(rd_data[LW-1:0]);
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[AW:1];
  assign val      = prod + PW'(icpt_q);
  assign keep_top = m1_q < prod;
  assign full     = n_q == CW'(MAX_LINES);

  // Line storage: slope in the upper half, intercept in the lower half
  lelmq_ram #(
    .WIDTH (2 * LW),
    .DEPTH (MAX_LINES)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (n_q[AW-1:0]),
    .wr_data_i ({a_q, b_q}),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (rd_data)
  );

  lelmq_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lelmq_pkg::S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser) begin
            state_d = (cnt_q == '0) ? lelmq_pkg::S_DONE : lelmq_pkg::S_QLOOP;
          end else begin
            state_d = (cnt_q == '0) ? lelmq_pkg::S_PUSH : lelmq_pkg::S_TOP;
          end
        end
      end
      lelmq_pkg::S_TOP: begin
        state_d = (a_q > rd_slope) ? lelmq_pkg::S_DONE : lelmq_pkg::S_RD_PREV;
      end
      lelmq_pkg::S_RD_PREV: begin
        state_d = (n_q >= CW'(2)) ? lelmq_pkg::S_DIFF : lelmq_pkg::S_PUSH;
      end
      lelmq_pkg::S_DIFF:  state_d = lelmq_pkg::S_MUL_A;
      lelmq_pkg::S_MUL_A: state_d = lelmq_pkg::S_MUL_B;
      lelmq_pkg::S_MUL_B: state_d = lelmq_pkg::S_CMP;
      lelmq_pkg::S_CMP: begin
        state_d = keep_top ? lelmq_pkg::S_PUSH : lelmq_pkg::S_RD_PREV;
      end
      lelmq_pkg::S_PUSH:  state_d = lelmq_pkg::S_DONE;
      lelmq_pkg::S_QLOOP: state_d = lelmq_pkg::S_QMUL;
      lelmq_pkg::S_QMUL:  state_d = lelmq_pkg::S_QADD;
      lelmq_pkg::S_QADD: begin
        case (qsel_q)
          lelmq_pkg::QS_MID:  state_d = lelmq_pkg::S_QMUL;
          lelmq_pkg::QS_NEXT: state_d = lelmq_pkg::S_QLOOP;
          default:            state_d = lelmq_pkg::S_DONE;
        endcase
      end
      lelmq_pkg::S_DONE: begin
        if (out_free) begin
          state_d = lelmq_pkg::S_IDLE;
        end
      end
      default: state_d = lelmq_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: RAM port, multiplier, handshake
  always_comb begin
    s_axis_tready = state_q == lelmq_pkg::S_IDLE;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = '0;
    ram_wr_en     = 1'b0;
    mul_req       = '0;
    case (state_q)
      lelmq_pkg::S_IDLE: begin
        ram_rd_en   = accept && !s_axis_tuser && (cnt_q != '0);
        ram_rd_addr = AW'(cnt_q - CW'(1));
      end
      lelmq_pkg::S_RD_PREV: begin
        ram_rd_en   = n_q >= CW'(2);
        ram_rd_addr = AW'(n_q - CW'(2));
      end
      lelmq_pkg::S_MUL_A: begin
        mul_req = '{en: 1'b1, op_a: p1_q, op_b: q1_q};
      end
      lelmq_pkg::S_MUL_B: begin
        mul_req = '{en: 1'b1, op_a: p2_q, op_b: q2_q};
      end
      lelmq_pkg::S_PUSH: begin
        ram_wr_en = !full;
      end
      lelmq_pkg::S_QLOOP: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = (lo_q < hi_q) ? mid : lo_q;
      end
      lelmq_pkg::S_QMUL: begin
        mul_req = '{en: 1'b1, op_a: DW'(rd_slope), op_b: DW'(x_q)};
      end
      lelmq_pkg::S_QADD: begin
        ram_rd_en   = qsel_q == lelmq_pkg::QS_MID;
        ram_rd_addr = mid + AW'(1);
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= lelmq_pkg::S_IDLE;
      cnt_q         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == lelmq_pkg::S_PUSH && !full) begin
        cnt_q <= n_q + CW'(1);
      end
      if (state_q == lelmq_pkg::S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      lelmq_pkg::S_IDLE: begin
        if (accept) begin
          a_q       <= in_slope;
          b_q       <= $signed(s_axis_tdata[2*LW-1:LW]);
          x_q       <= $signed(s_axis_tdata[3*LW-1:2*LW]);
          n_q       <= cnt_q;
          lo_q      <= '0;
          hi_q      <= AW'(cnt_q - CW'(1));
          res_val_q <= '0;
          res_stat_q <= (s_axis_tuser && cnt_q == '0) ? lelmq_pkg::STAT_EMPTY
                                                      : lelmq_pkg::STAT_OK;
        end
      end
      lelmq_pkg::S_TOP: begin
        top_a_q <= rd_slope;
        top_b_q <= rd_icpt;
        if (a_q > rd_slope) begin
          res_stat_q <= lelmq_pkg::STAT_SLOPE;
        end
      end
      lelmq_pkg::S_DIFF: begin
        p1_q <= DW'(rd_slope) - DW'(top_a_q);
        q1_q <= DW'(rd_icpt) - DW'(b_q);
        p2_q <= DW'(rd_slope) - DW'(a_q);
        q2_q <= DW'(rd_icpt) - DW'(top_b_q);
      end
      lelmq_pkg::S_MUL_B: begin
        m1_q <= prod;
      end
      lelmq_pkg::S_CMP: begin
        // Drop the top line; the one below becomes the top
        if (!keep_top) begin
          n_q     <= n_q - CW'(1);
          top_a_q <= rd_slope;
          top_b_q <= rd_icpt;
        end
      end
      lelmq_pkg::S_PUSH: begin
        if (full) begin
          res_stat_q <= lelmq_pkg::STAT_FULL;
        end
      end
      lelmq_pkg::S_QLOOP: begin
        qsel_q <= (lo_q < hi_q) ? lelmq_pkg::QS_MID : lelmq_pkg::QS_FINAL;
      end
      lelmq_pkg::S_QMUL: begin
        icpt_q <= rd_icpt;
      end
      lelmq_pkg::S_QADD: begin
        case (qsel_q)
          lelmq_pkg::QS_MID: begin
            v1_q   <= val;
            qsel_q <= lelmq_pkg::QS_NEXT;
          end
          lelmq_pkg::QS_NEXT: begin
            // Narrow the search towards the smaller value
            if (v1_q <= val) begin
              hi_q <= mid;
            end else begin
              lo_q <= mid + AW'(1);
            end
          end
          default: begin
            res_val_q <= val[lelmq_pkg::VAL_W-1:0];
          end
        endcase
      end
      lelmq_pkg::S_DONE: begin
        if (out_free) begin
          m_axis_tdata <= {3'b000, lelmq_pkg::HELD_W'(cnt_q), res_stat_q, res_val_q};
        end
      end
      default: begin
      end
    endcase
  end

endmodule : lower_envelope_line_min_query

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lower_envelope_line_min_query. A behavioural
// envelope predictor runs beside the block. The directed tests cover an empty
// query, extreme slopes and intercepts, equal slopes, a slope out of order and
// a full stack. A random phase follows with descending adds, queries and adds
// with a slope out of order. The sender works in bursts and the result side
// stalls on a pattern of its own.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int        DEPTH       = lelmq_pkg::MAX_LINES_DEF;
  localparam int        LIMIT       = 1_500_000;
  localparam int        EXP_DEPTH   = 16;
  localparam bit        FN_ADD      = 1'b0;
  localparam bit        FN_QUERY    = 1'b1;
  localparam longint    SLOPE_FLOOR = -64'sd2147483648 + 64'sd8192;

  typedef struct {
    longint             min_val;
    lelmq_pkg::status_e stat;
    logic [10:0]        held;
  } envelope_res_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // slope [31:0], intercept [63:32], query_x [95:64]
  logic [lelmq_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  // func [0]
  logic                            s_axis_tuser = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // min_value [63:0], status [65:64], lines_held [76:66], zero [79:77]
  logic [lelmq_pkg::M_TDATA_W-1:0] m_axis_tdata;

  // Predictor state
  logic signed [31:0] env_slope [DEPTH];
  logic signed [31:0] env_icpt  [DEPTH];
  int                 env_count = 0;

  // Expected results in order of acceptance
  envelope_res_t      exp_ring [EXP_DEPTH];
  int                 exp_wr = 0;
  int                 exp_rd = 0;
  int                 fail_count = 0;
  int                 cycle_count = 0;
  int                 burst_left = 0;

  lower_envelope_line_min_query uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Value of stored line k at x
  function automatic longint line_value(int k, longint x);
    return longint'(env_slope[k]) * x + longint'(env_icpt[k]);
  endfunction

  // Apply one item to the predicted envelope and return its result
  function automatic envelope_res_t envelope_step(bit fn, logic signed [31:0] a,
                                                  logic signed [31:0] b,
                                                  logic signed [31:0] x);
    envelope_res_t      r;
    int                 lo;
    int                 hi;
    int                 mi;
    int                 n;
    logic signed [32:0] d1, d2, d3, d4;
    logic signed [65:0] p_keep, p_pop;
    r.min_val = 0;
    r.stat    = lelmq_pkg::STAT_OK;
    if (fn == FN_QUERY) begin
      if (env_count == 0) begin
        r.stat = lelmq_pkg::STAT_EMPTY;
      end else begin
        lo = 0;
        hi = env_count - 1;
        while (lo < hi) begin
          mi = (lo + hi) / 2;
          if (line_value(mi, x) <= line_value(mi + 1, x)) hi = mi;
          else lo = mi + 1;
        end
        r.min_val = line_value(lo, x);
      end
    end else if (env_count > 0 && a > env_slope[env_count-1]) begin
      r.stat = lelmq_pkg::STAT_SLOPE;
    end else begin
      // Drop top lines that the new line makes redundant
      n = env_count;
      while (n >= 2) begin
        d1 = 33'(env_slope[n-2]) - 33'(env_slope[n-1]);
        d2 = 33'(env_icpt[n-2]) - 33'(b);
        d3 = 33'(env_slope[n-2]) - 33'(a);
        d4 = 33'(env_icpt[n-2]) - 33'(env_icpt[n-1]);
        p_keep = d1 * d2;
        p_pop  = d3 * d4;
        if (p_keep < p_pop) break;
        n--;
      end
      if (n >= DEPTH) begin
        r.stat = lelmq_pkg::STAT_FULL;
      end else begin
        env_slope[n] = a;
        env_icpt[n]  = b;
        env_count    = n + 1;
      end
    end
    r.held = env_count[10:0];
    return r;
  endfunction

  // Send one item, in bursts with random gaps
  task automatic send_item(bit fn, logic signed [31:0] a, logic signed [31:0] b,
                           logic signed [31:0] x);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {x, b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    exp_ring[exp_wr % EXP_DEPTH] = envelope_step(fn, a, b, x);
    exp_wr++;
    @(negedge clk_i);
  endtask

  task automatic add_line(longint a, longint b);
    send_item(FN_ADD, a[31:0], b[31:0], $urandom());
  endtask

  task automatic query_min(longint x);
    send_item(FN_QUERY, $urandom(), $urandom(), x[31:0]);
  endtask

  // Report one mismatch and count it
  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    envelope_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (exp_wr == exp_rd) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        e = exp_ring[exp_rd % EXP_DEPTH];
        exp_rd++;
        if ($signed(m_axis_tdata[63:0]) != e.min_val)
          report_mismatch("min_value", $signed(m_axis_tdata[63:0]), e.min_val);
        if (m_axis_tdata[65:64] != e.stat)
          report_mismatch("status", m_axis_tdata[65:64], e.stat);
        if (m_axis_tdata[76:66] != e.held)
          report_mismatch("lines_held", m_axis_tdata[76:66], e.held);
      end
    end
  end

  // Result-side stall pattern: the mode steps through four patterns in turn
  always @(negedge clk_i) begin
    int mode;
    mode = (cycle_count / 64) % 4;
    case (mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= (cycle_count % 5 != 0);
    endcase
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("lower_envelope_line_min_query test failed");
      $finish;
    end
  end

  // Query on an empty store, then extreme and equal slopes, order error
  task automatic test_directed();
    query_min(0);
    query_min(64'sd2147483647);
    add_line(64'sd2147483647, -64'sd2147483648);
    add_line(64'sd2147483647, 64'sd2147483647);
    add_line(64'sd2147483647, -64'sd5);
    add_line(0, 0);
    add_line(0, 0);
    add_line(-64'sd3, 64'sd2147483647);
    add_line(5, 1);
    query_min(-64'sd2147483648);
    query_min(64'sd2147483647);
    query_min(0);
    query_min(-1);
    add_line(-64'sd3, -64'sd2147483648);
    query_min(1);
  endtask

  // Descending adds with random content, queries and out-of-order noise
  task automatic test_random(int items);
    longint top;
    longint a;
    int     pick;
    for (int i = 0; i < items; i++) begin
      top  = (env_count == 0) ? 64'sd2147483647 : longint'(env_slope[env_count-1]);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        case ($urandom_range(0, 3))
          0: query_min($urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648);
          1: query_min($signed($urandom_range(0, 2000)) - 1000);
          default: query_min(longint'($signed($urandom())));
        endcase
      end else if (pick < 40 && top < 64'sd2147483647) begin
        add_line(top + $urandom_range(1, 1000), longint'($signed($urandom())));
      end else begin
        a = top - $urandom_range(0, 1 << $urandom_range(0, 20));
        if (a < SLOPE_FLOOR) a = SLOPE_FLOOR;
        add_line(a, $urandom_range(0, 3) == 0 ? longint'($signed($urandom_range(0, 64)))
                                              : longint'($signed($urandom())));
      end
    end
  endtask

  // Fill the store with lines that all stay on the envelope, then overflow
  task automatic test_full();
    longint base;
    longint k;
    base = longint'(env_slope[env_count-1]) - 1;
    k = 1;
    while (env_count < DEPTH) begin
      add_line(base - k, k * k);
      k++;
    end
    for (int i = 0; i < 3; i++) begin
      add_line(base - k, k * k);
      k++;
    end
    query_min(0);
    query_min(-64'sd2147483648);
    query_min(64'sd500);
    // Steep line that clears much of the stack, then the extreme slope
    add_line(-64'sd2147483648, 64'sd2147483647);
    add_line(-64'sd2147483648, -64'sd2147483648);
    query_min(64'sd2147483647);
    query_min(-64'sd2147483648);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(720);
    test_full();
    s_axis_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("lower_envelope_line_min_query test passed");
    end else begin
      $display("lower_envelope_line_min_query test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== lower_envelope_line_min_query.f =====
hw/rtl/lelmq_pkg.sv
hw/rtl/lelmq_ram.sv
hw/rtl/lelmq_mul.sv
hw/rtl/lower_envelope_line_min_query.sv
tb/sv/tb.sv
